/* rtl/lpc_pkg.sv */
// Shared types, constants and helper function of the longest-prefix classifier.
`default_nettype none

package lpc_pkg;

   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 6;
   localparam int GROUP_W  = 32;

   localparam logic [LEN_W-1:0] MAX_PREFIX_LEN = 6'd32;

   typedef enum logic [0:0] {
      CMD_LOOKUP = 1'b0,
      CMD_INSERT = 1'b1
   } lpc_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } lpc_state_type;

   typedef struct packed {
      logic                 command;
      logic [ADDR_W-1:0]    key_addr;
      logic [LEN_W-1:0]     mask_len;
      logic [GROUP_W-1:0]   group_id;
   } lpc_request_type;

   typedef struct packed {
      logic                 hit;
      logic [GROUP_W-1:0]   match_group;
      logic                 table_full;
   } lpc_result_type;

   typedef struct packed {
      logic [ADDR_W-1:0]    addr;
      logic [LEN_W-1:0]     length;
      logic [GROUP_W-1:0]   group;
   } lpc_rule_type;

   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] mask;
      if (len == '0) begin
         mask = '0;
      end else begin
         mask = {ADDR_W{1'b1}} << (MAX_PREFIX_LEN - len);
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

/* rtl/lpc_if.sv */
// Valid/ready channel interfaces for request and response items.
`default_nettype none

interface lpc_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] key_addr;
   logic [5:0]  mask_len;
   logic [31:0] group_id;

   modport source (output valid, command, key_addr, mask_len, group_id, input ready);
   modport sink   (input valid, command, key_addr, mask_len, group_id, output ready);
endinterface

interface lpc_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] match_group;
   logic        table_full;

   modport source (output valid, hit, match_group, table_full, input ready);
   modport sink   (input valid, hit, match_group, table_full, output ready);
endinterface

`default_nettype wire

/* rtl/lpc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module lpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/lpc_engine.sv */
// Rule table, insert logic and sequential longest-prefix scan over the rule memory.
`default_nettype none

module lpc_engine
   import lpc_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire lpc_request_type req_data,
   output logic                 res_valid,
   input  wire logic            res_ready,
   output lpc_result_type       res_data
);

   lpc_state_type   state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0] key_ff, key_in;
   logic            found_ff, found_in;
   logic [LEN_W-1:0] best_len_ff, best_len_in;
   logic [GROUP_W-1:0] best_group_ff, best_group_in;
   lpc_result_type  res_ff, res_in;

   logic            wr_en;
   logic [AW-1:0]   rd_addr;
   lpc_rule_type    wr_rule;
   lpc_rule_type    rd_rule;
   logic            is_full;
   logic            accept;
   logic            rule_match;
   logic            take;
   logic            last_rule;

   lpc_ram #(
      .WIDTH ($bits(lpc_rule_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_rule),
      .rd_addr (rd_addr),
      .rd_data (rd_rule)
   );

   assign is_full    = (count_ff == CW'(TABLE_DEPTH));
   assign rule_match = (((rd_rule.addr ^ key_ff) & prefix_mask(rd_rule.length)) == '0);
   assign take       = rule_match && (!found_ff || (rd_rule.length > best_len_ff));
   assign last_rule  = ((CW'(idx_ff) + CW'(1)) == count_ff);

   always_comb begin
      wr_rule.addr   = req_data.key_addr;
      wr_rule.length = (req_data.mask_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN
                                                            : req_data.mask_len;
      wr_rule.group  = req_data.group_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff        <= idx_in;
      key_ff        <= key_in;
      found_ff      <= found_in;
      best_len_ff   <= best_len_in;
      best_group_ff <= best_group_in;
      res_ff        <= res_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      found_in      = found_ff;
      best_len_in   = best_len_ff;
      best_group_in = best_group_ff;
      res_in        = res_ff;
      wr_en         = 1'b0;
      rd_addr       = '0;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      accept        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept) begin
               res_in = '0;
               if (req_data.command == CMD_INSERT) begin
                  if (is_full) begin
                     res_in.table_full = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
                  state_in = ST_DONE;
               end else if (count_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  key_in   = req_data.key_addr;
                  idx_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (take) begin
               found_in      = 1'b1;
               best_len_in   = rd_rule.length;
               best_group_in = rd_rule.group;
            end
            if (last_rule) begin
               res_in.hit         = found_in;
               res_in.match_group = found_in ? best_group_in : '0;
               res_in.table_full  = 1'b0;
               state_in           = ST_DONE;
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(1);
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_data = res_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("Rule count exceeds the table depth.");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CW'(idx_ff) < count_ff))
      else $error("Scan index points past the stored rules.");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.command == CMD_INSERT && !is_full)
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("Accepted insert did not advance the rule count.");

   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(res_data.hit && res_data.table_full))
      else $error("Result flags both a hit and a full table.");

   a_miss_zero_group: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_data.hit) |-> (res_data.match_group == '0))
      else $error("Result without a hit carries a group id.");
`endif

endmodule

`default_nettype wire

/* rtl/ipv4_longest_prefix_classifier_core.sv */
// IPv4 longest-prefix classifier top level with the response output register.
// An insert item appends one rule to the table, or is dropped with table_full set when the
// table already holds TABLE_DEPTH rules; a lookup item scans all stored rules in insertion
// order and returns the group of the longest matching prefix, the earliest at equal length.
// The rule memory has one read port, so a lookup reads one rule per cycle: it goes from idle
// through the scan state, which reads the stored rules in turn, to the done state; an insert or
// a lookup of an empty table goes straight from idle to done. One item is in work at a time;
// the next one is accepted once the previous result has moved into the output register.
`default_nettype none

module ipv4_longest_prefix_classifier_core
   import lpc_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lpc_req_if.sink    req_ch,
   lpc_rsp_if.source  rsp_ch
);

   lpc_request_type req_data;
   lpc_result_type  res_data;
   logic            res_valid;
   logic            res_ready;
   logic            rsp_valid_ff, rsp_valid_in;
   lpc_result_type  rsp_data_ff, rsp_data_in;
   logic            req_ready;

   always_comb begin
      req_data.command  = req_ch.command;
      req_data.key_addr = req_ch.key_addr;
      req_data.mask_len = req_ch.mask_len;
      req_data.group_id = req_ch.group_id;
   end

   assign req_ch.ready = req_ready;

   lpc_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = rsp_data_ff.hit;
   assign rsp_ch.match_group = rsp_data_ff.match_group;
   assign rsp_ch.table_full  = rsp_data_ff.table_full;

endmodule

`default_nettype wire
